// ===== hw/rtl/tkfs_pkg.sv =====
// Package: shared constants, payload structs and controller/datapath interface types.
`default_nettype none
package tkfs_pkg;

    localparam int MAX_ELITES     = 16;
    localparam int MAX_POPULATION = 1024;

    localparam int FIT_W      = 32;
    localparam int NUM_ELIT_W = 5;
    localparam int IDX_W      = $clog2(MAX_POPULATION);
    localparam int ARR_W      = IDX_W + 1;
    localparam int SLOT_W     = (MAX_ELITES > 1) ? $clog2(MAX_ELITES) : 1;
    localparam int CNT_W      = $clog2(MAX_ELITES + 1);

    typedef struct packed {
        logic signed [FIT_W-1:0] fitness;
        logic                    last_item;
    } in_beat_t;

    typedef struct packed {
        logic [IDX_W-1:0]        elite_index;
        logic signed [FIT_W-1:0] elite_fitness;
        logic                    last_of_run;
        logic                    overflow;
    } out_beat_t;

    typedef struct packed {
        logic              insert;
        logic              clear;
        logic              load_out;
        logic              out_last;
        logic [SLOT_W-1:0] rd_ptr;
    } dp_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] held_after;
        logic             out_free;
    } dp_status_t;

    typedef enum logic [1:0] {
        ST_COLLECT = 2'b01,
        ST_EMIT    = 2'b10
    } tkfs_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tkfs_datapath.sv =====
// Datapath: sorted elite list with parallel compare-and-shift insertion, counters, output register.
`default_nettype none
module tkfs_datapath
    import tkfs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire in_beat_t   in_data,
    input  wire dp_cmd_t    cmd,
    output dp_status_t      status,
    input  wire logic       out_stall,
    output logic            out_valid,
    output out_beat_t       out_data
);

    logic signed [FIT_W-1:0] fit_reg [MAX_ELITES];
    logic signed [FIT_W-1:0] fit_next [MAX_ELITES];
    logic [IDX_W-1:0]        idx_reg [MAX_ELITES];
    logic [IDX_W-1:0]        idx_next [MAX_ELITES];
    logic [CNT_W-1:0]        held_reg, held_next;
    logic [ARR_W-1:0]        arrival_reg, arrival_next;
    logic                    overflow_reg, overflow_next;
    logic                    out_valid_reg, out_valid_next;
    out_beat_t               out_reg, out_next;
    logic [MAX_ELITES-1:0]   ge;
    logic                    rank_ok;
    logic                    do_insert;
    logic [CNT_W-1:0]        held_ins;

    assign rank_ok   = arrival_reg < ARR_W'(MAX_POPULATION);
    assign do_insert = cmd.insert && rank_ok;
    assign held_ins  = (do_insert && (held_reg < CNT_W'(MAX_ELITES)))
                       ? held_reg + CNT_W'(1) : held_reg;

    // entries at or above the new value keep their place; ties stay ahead
    always_comb
    begin
        for (int i = 0; i < MAX_ELITES; i++)
        begin
            ge[i] = (CNT_W'(i) < held_reg) && (fit_reg[i] >= in_data.fitness);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_ELITES; i++)
        begin
            fit_next[i] = fit_reg[i];
            idx_next[i] = idx_reg[i];
            if (do_insert && !ge[i])
            begin
                if (i == 0)
                begin
                    fit_next[i] = in_data.fitness;
                    idx_next[i] = arrival_reg[IDX_W-1:0];
                end
                else if (ge[(i > 0) ? i - 1 : 0])
                begin
                    fit_next[i] = in_data.fitness;
                    idx_next[i] = arrival_reg[IDX_W-1:0];
                end
                else
                begin
                    fit_next[i] = fit_reg[(i > 0) ? i - 1 : 0];
                    idx_next[i] = idx_reg[(i > 0) ? i - 1 : 0];
                end
            end
        end
    end

    always_comb
    begin
        held_next     = held_ins;
        arrival_next  = arrival_reg;
        overflow_next = overflow_reg;
        if (cmd.insert)
        begin
            if (rank_ok)
                arrival_next = arrival_reg + ARR_W'(1);
            else
                overflow_next = 1'b1;
        end
        if (cmd.clear)
        begin
            held_next     = '0;
            arrival_next  = '0;
            overflow_next = 1'b0;
        end
    end

    assign status.held_after = held_ins;
    assign status.out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_next.elite_index   = idx_reg[cmd.rd_ptr];
            out_next.elite_fitness = fit_reg[cmd.rd_ptr];
            out_next.last_of_run   = cmd.out_last;
            out_next.overflow      = overflow_reg;
            out_valid_next         = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ELITES; i++)
        begin
            fit_reg[i] <= fit_next[i];
            idx_reg[i] <= idx_next[i];
        end
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            arrival_reg   <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            arrival_reg   <= arrival_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(MAX_ELITES))
        else $error("elite count above list depth");

    a_held_arrivals: assert property (@(posedge clk) disable iff (!rst_n)
        ARR_W'(held_reg) <= arrival_reg)
        else $error("more list entries than arrivals");

    generate
        for (genvar g = 0; g + 1 < MAX_ELITES; g++)
        begin : g_sorted
            a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                (CNT_W'(g + 1) < held_reg) |-> (fit_reg[g] >= fit_reg[g + 1]))
                else $error("elite list out of order");
        end
    endgenerate
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/tkfs_controller.sv =====
// Controller: collect/emit state machine, num_elites register and emit sequencing.
`default_nettype none
module tkfs_controller
    import tkfs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [NUM_ELIT_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    input  wire logic                  in_last,
    output logic                       in_stall,
    input  wire dp_status_t            status,
    output dp_cmd_t                    cmd
);

    tkfs_state_t            state_reg, state_next;
    logic [NUM_ELIT_W-1:0]  num_elites_reg, num_elites_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SLOT_W-1:0]      ptr_reg, ptr_next;
    logic [CNT_W-1:0]       want;
    logic [CNT_W-1:0]       n_sel;
    logic                   accept;
    logic                   final_beat;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_COLLECT);
    assign accept    = in_valid && !in_stall;

    assign want  = (NUM_ELIT_W'(num_elites_reg) > NUM_ELIT_W'(MAX_ELITES))
                   ? CNT_W'(MAX_ELITES) : CNT_W'(num_elites_reg);
    assign n_sel = (want < status.held_after) ? want : status.held_after;
    assign final_beat = (CNT_W'(ptr_reg) + CNT_W'(1)) == count_reg;

    always_comb
    begin
        num_elites_next = cfg_valid ? cfg_data : num_elites_reg;
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        cmd             = '0;
        cmd.rd_ptr      = ptr_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                cmd.insert = accept;
                if (accept && in_last)
                begin
                    if (n_sel == '0)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else
                    begin
                        count_next = n_sel;
                        ptr_next   = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_last = final_beat;
                    if (final_beat)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_COLLECT;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + SLOT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_COLLECT;
            num_elites_reg <= NUM_ELIT_W'(1);
            count_reg      <= '0;
            ptr_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            num_elites_reg <= num_elites_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
        end
    end

`ifndef SYNTHESIS
    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> ((count_reg != '0) && (CNT_W'(ptr_reg) < count_reg)))
        else $error("emit pointer outside selected range");

    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && cmd.out_last) |=> (state_reg == ST_COLLECT))
        else $error("controller stayed in emit after final beat");

    a_no_clear_mid_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && cmd.clear) |-> (cmd.load_out && cmd.out_last))
        else $error("list cleared before final beat was sent");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/top_k_fitness_selector_unit.sv =====
// Top level: top-k fitness selector, controller plus datapath.
// Items are taken one per cycle while a population is collected; each is ranked
// against a sorted list of up to MAX_ELITES entries by a parallel compare-and-shift
// in the same cycle. The beat marked last closes the population: the input then
// stalls while min(num_elites, items held) results are read out through the
// list's single read port, one per cycle unless the output stalls, best first.
// With nothing to report the population closes in that same cycle. No clearing
// pass.
`default_nettype none
module top_k_fitness_selector_unit
    import tkfs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [NUM_ELIT_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_beat_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_beat_t                  out_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    tkfs_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_last   (in_data.last_item),
        .in_stall  (in_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tkfs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire
